// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/tbo_pkg.sv -----
// Package: shared types and register codes for the triangle/box overlap test
`timescale 1ns / 1ps
`default_nettype none

package tbo_pkg;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	// load enables for the product and compare stages
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

`default_nettype wire

// ----- design/tbo_axis_test.sv -----
// One edge-cross-box-axis separating test: products stage, then spans and compare
`timescale 1ns / 1ps
`default_nettype none

module tbo_axis_test #(
	parameter int W = 16
) (
	input  wire logic                    clk,
	input  wire tbo_pkg::stage_en_t      en,
	input  wire logic signed [W+1:0]     u,
	input  wire logic signed [W+1:0]     w,
	input  wire logic signed [W-1:0]     vp [3],
	input  wire logic signed [W-1:0]     vq [3],
	input  wire logic signed [W-1:0]     bmin_p,
	input  wire logic signed [W-1:0]     bmax_p,
	input  wire logic signed [W-1:0]     bmin_q,
	input  wire logic signed [W-1:0]     bmax_q,
	output logic                         ok_s3
);

	localparam int PW = 2 * W + 2;
	localparam int SW = 2 * W + 3;

	logic signed [PW-1:0] tu_s2 [3];
	logic signed [PW-1:0] tw_s2 [3];
	logic signed [PW-1:0] bun_s2, bux_s2, bwn_s2, bwx_s2;

	logic signed [SW-1:0] t [3];
	logic signed [SW-1:0] tlo, thi, blo, bhi;
	logic signed [PW-1:0] ulo, uhi, wlo, whi;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < 3; k++) begin
				tu_s2[k] <= PW'(u) * PW'(vp[k]);
				tw_s2[k] <= PW'(w) * PW'(vq[k]);
			end
			bun_s2 <= PW'(u) * PW'(bmin_p);
			bux_s2 <= PW'(u) * PW'(bmax_p);
			bwn_s2 <= PW'(w) * PW'(bmin_q);
			bwx_s2 <= PW'(w) * PW'(bmax_q);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t[k] = SW'(tu_s2[k]) + SW'(tw_s2[k]);
		end
		tlo = t[0];
		thi = t[0];
		for (int k = 1; k < 3; k++) begin
			if (t[k] < tlo) tlo = t[k];
			if (thi < t[k]) thi = t[k];
		end
		ulo = (bux_s2 < bun_s2) ? bux_s2 : bun_s2;
		uhi = (bux_s2 < bun_s2) ? bun_s2 : bux_s2;
		wlo = (bwx_s2 < bwn_s2) ? bwx_s2 : bwn_s2;
		whi = (bwx_s2 < bwn_s2) ? bwn_s2 : bwx_s2;
		blo = SW'(ulo) + SW'(wlo);
		bhi = SW'(uhi) + SW'(whi);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ok_s3 <= !((bhi < tlo) || (thi < blo));
		end
	end

endmodule

`default_nettype wire

// ----- design/triangle_box_overlap_test_top.sv -----
// Top level: triangle vs. box separating-axis overlap test, five-stage pipeline
// The result is registered in stage 5 and is presented with out_valid, the stage 5 valid bit.
// Throughput: one triangle per cycle while out_ready holds; stages squeeze out bubbles under backpressure.
// The normal-axis test sets the depth: cross product, then dot products, then compare.
// Reset: arst_n clears the pipeline valid bits and all six box registers to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_box_overlap_test_top #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tbo_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] vert_a_x,
	input  wire logic signed [COORD_WIDTH-1:0] vert_a_y,
	input  wire logic signed [COORD_WIDTH-1:0] vert_a_z,
	input  wire logic signed [COORD_WIDTH-1:0] vert_b_x,
	input  wire logic signed [COORD_WIDTH-1:0] vert_b_y,
	input  wire logic signed [COORD_WIDTH-1:0] vert_b_z,
	input  wire logic signed [COORD_WIDTH-1:0] vert_c_x,
	input  wire logic signed [COORD_WIDTH-1:0] vert_c_y,
	input  wire logic signed [COORD_WIDTH-1:0] vert_c_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               overlaps
);

	localparam int W   = COORD_WIDTH;
	localparam int EW  = W + 1;
	localparam int NPW = 2 * W + 2;
	localparam int NW  = 2 * W + 3;
	localparam int QW  = 3 * W + 3;
	localparam int OW  = 3 * W + 5;

	// ---------------- configuration ----------------
	logic signed [W-1:0] bmin_q [3];
	logic signed [W-1:0] bmax_q [3];
	logic [2:0]          reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				bmin_q[k] <= '0;
				bmax_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			case (tbo_pkg::reg_idx_t'(reg_idx))
				tbo_pkg::REG_MIN_X: bmin_q[0] <= pwdata[W-1:0];
				tbo_pkg::REG_MIN_Y: bmin_q[1] <= pwdata[W-1:0];
				tbo_pkg::REG_MIN_Z: bmin_q[2] <= pwdata[W-1:0];
				tbo_pkg::REG_MAX_X: bmax_q[0] <= pwdata[W-1:0];
				tbo_pkg::REG_MAX_Y: bmax_q[1] <= pwdata[W-1:0];
				tbo_pkg::REG_MAX_Z: bmax_q[2] <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (tbo_pkg::reg_idx_t'(reg_idx))
			tbo_pkg::REG_MIN_X: prdata = 32'(bmin_q[0]);
			tbo_pkg::REG_MIN_Y: prdata = 32'(bmin_q[1]);
			tbo_pkg::REG_MIN_Z: prdata = 32'(bmin_q[2]);
			tbo_pkg::REG_MAX_X: prdata = 32'(bmax_q[0]);
			tbo_pkg::REG_MAX_Y: prdata = 32'(bmax_q[1]);
			tbo_pkg::REG_MAX_Z: prdata = 32'(bmax_q[2]);
			default:            prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	tbo_pkg::stage_en_t en;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign en.s2    = rdy2;
	assign en.s3    = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: vertices, edges, box-axis test ----------------
	logic signed [W-1:0]  vin [3][3];
	logic signed [W-1:0]  vert_s1 [3][3];
	logic signed [EW-1:0] e_s1 [3][3];
	logic                 box_ok_s1;
	logic                 box_ok;
	logic signed [W-1:0]  lo, hi;

	always_comb begin
		vin[0][0] = vert_a_x; vin[0][1] = vert_a_y; vin[0][2] = vert_a_z;
		vin[1][0] = vert_b_x; vin[1][1] = vert_b_y; vin[1][2] = vert_b_z;
		vin[2][0] = vert_c_x; vin[2][1] = vert_c_y; vin[2][2] = vert_c_z;
		box_ok = 1'b1;
		for (int j = 0; j < 3; j++) begin
			lo = vin[0][j];
			hi = vin[0][j];
			for (int i = 1; i < 3; i++) begin
				if (vin[i][j] < lo) lo = vin[i][j];
				if (vin[i][j] > hi) hi = vin[i][j];
			end
			if ((hi < bmin_q[j]) || (lo > bmax_q[j])) box_ok = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			box_ok_s1 <= box_ok;
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) vert_s1[i][j] <= vin[i][j];
				e_s1[0][j] <= EW'(vin[0][j]) - EW'(vin[1][j]);
				e_s1[1][j] <= EW'(vin[1][j]) - EW'(vin[2][j]);
				e_s1[2][j] <= EW'(vin[2][j]) - EW'(vin[0][j]);
			end
		end
	end

	// ---------------- edge axes: nine units, result at stage 3 ----------------
	logic [8:0] edge_ok_s3;

	for (genvar gi = 0; gi < 3; gi++) begin : g_edge
		for (genvar gj = 0; gj < 3; gj++) begin : g_axis
			localparam int P = (gj == 0) ? 1 : 0;
			localparam int Q = (gj == 2) ? 1 : 2;
			logic signed [W+1:0] u, w;
			logic signed [W-1:0] vp [3];
			logic signed [W-1:0] vq [3];

			// edge x unit axis: x -> (0, ez, -ey), y -> (-ez, 0, ex), z -> (ey, -ex, 0)
			if (gj == 0) begin : g_x
				assign u = (W+2)'(e_s1[gi][2]);
				assign w = -(W+2)'(e_s1[gi][1]);
			end else if (gj == 1) begin : g_y
				assign u = -(W+2)'(e_s1[gi][2]);
				assign w = (W+2)'(e_s1[gi][0]);
			end else begin : g_z
				assign u = (W+2)'(e_s1[gi][1]);
				assign w = -(W+2)'(e_s1[gi][0]);
			end

			for (genvar gk = 0; gk < 3; gk++) begin : g_v
				assign vp[gk] = vert_s1[gk][P];
				assign vq[gk] = vert_s1[gk][Q];
			end

			tbo_axis_test #(.W(W)) u_axis (
				.clk    (clk),
				.en     (en),
				.u      (u),
				.w      (w),
				.vp     (vp),
				.vq     (vq),
				.bmin_p (bmin_q[P]),
				.bmax_p (bmax_q[P]),
				.bmin_q (bmin_q[Q]),
				.bmax_q (bmax_q[Q]),
				.ok_s3  (edge_ok_s3[gi*3+gj])
			);
		end
	end

	// ---------------- normal axis ----------------
	// n = e0 x e2, the negative of (b-a) x (c-a); the interval test ignores the sign
	logic signed [NPW-1:0] np_s2 [6];
	logic signed [W-1:0]   a_s2 [3];
	logic signed [W-1:0]   a_s3 [3];
	logic signed [NW-1:0]  n_s3 [3];
	logic                  box_ok_s2, box_ok_s3;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			np_s2[0] <= NPW'(e_s1[0][1]) * NPW'(e_s1[2][2]);
			np_s2[1] <= NPW'(e_s1[0][2]) * NPW'(e_s1[2][1]);
			np_s2[2] <= NPW'(e_s1[0][2]) * NPW'(e_s1[2][0]);
			np_s2[3] <= NPW'(e_s1[0][0]) * NPW'(e_s1[2][2]);
			np_s2[4] <= NPW'(e_s1[0][0]) * NPW'(e_s1[2][1]);
			np_s2[5] <= NPW'(e_s1[0][1]) * NPW'(e_s1[2][0]);
			for (int k = 0; k < 3; k++) a_s2[k] <= vert_s1[0][k];
			box_ok_s2 <= box_ok_s1;
		end
		if (rdy3) begin
			n_s3[0] <= NW'(np_s2[0]) - NW'(np_s2[1]);
			n_s3[1] <= NW'(np_s2[2]) - NW'(np_s2[3]);
			n_s3[2] <= NW'(np_s2[4]) - NW'(np_s2[5]);
			for (int k = 0; k < 3; k++) a_s3[k] <= a_s2[k];
			box_ok_s3 <= box_ok_s2;
		end
	end

	logic signed [QW-1:0] na_s4  [3];
	logic signed [QW-1:0] nmn_s4 [3];
	logic signed [QW-1:0] nmx_s4 [3];
	logic                 ok_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int k = 0; k < 3; k++) begin
				na_s4[k]  <= QW'(n_s3[k]) * QW'(a_s3[k]);
				nmn_s4[k] <= QW'(n_s3[k]) * QW'(bmin_q[k]);
				nmx_s4[k] <= QW'(n_s3[k]) * QW'(bmax_q[k]);
			end
			ok_s4 <= box_ok_s3 && (&edge_ok_s3);
		end
	end

	logic signed [OW-1:0] off, nblo, nbhi;
	logic                 overlaps_s5;

	always_comb begin
		off  = '0;
		nblo = '0;
		nbhi = '0;
		for (int k = 0; k < 3; k++) begin
			off = off + OW'(na_s4[k]);
			if (nmx_s4[k] < nmn_s4[k]) begin
				nblo = nblo + OW'(nmx_s4[k]);
				nbhi = nbhi + OW'(nmn_s4[k]);
			end else begin
				nblo = nblo + OW'(nmn_s4[k]);
				nbhi = nbhi + OW'(nmx_s4[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			overlaps_s5 <= ok_s4 && !((nbhi < off) || (off < nblo));
		end
	end

	assign out_valid = v_s5;
	assign overlaps  = overlaps_s5;

	// ---------------- assertions ----------------
	`ASSERT_NEXT(a_in_loads_s1, in_valid && in_ready, v_s1)
	`ASSERT_ALWAYS(a_bubble_ready, (!v_s1 || !v_s2 || !v_s3 || !v_s4 || !v_s5) -> in_ready)
	`ASSERT_NEXT(a_s4_feeds_out, v_s4 && rdy5, out_valid)

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for the triangle/box overlap test: directed table, then random phases per box
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	typedef logic [8:0][15:0] tri_t;   // a.xyz, b.xyz, c.xyz

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [tbo_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	tri_t tri_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic overlaps;

	always #2 clk = ~clk;

	triangle_box_overlap_test_top #(.COORD_WIDTH(16)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.vert_a_x(tri_in[0]), .vert_a_y(tri_in[1]), .vert_a_z(tri_in[2]),
		.vert_b_x(tri_in[3]), .vert_b_y(tri_in[4]), .vert_b_z(tri_in[5]),
		.vert_c_x(tri_in[6]), .vert_c_y(tri_in[7]), .vert_c_z(tri_in[8]),
		.out_valid(out_valid), .out_ready(out_ready), .overlaps(overlaps)
	);

	logic signed [15:0] box_lo [3];
	logic signed [15:0] box_hi [3];
	bit overlap_q [$];
	int errors = 0;
	bit quiet = 1'b0;
	int stall_left = 0;
	int cycles = 0;

	function automatic longint dot3(input longint a [3], input longint b [3]);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// box corners projected per component; order taken from the products
	function automatic void box_proj(input longint ax [3], output longint lo, output longint hi);
		longint p, q, t;
		lo = 0;
		hi = 0;
		for (int k = 0; k < 3; k++) begin
			p = ax[k] * longint'(box_lo[k]);
			q = ax[k] * longint'(box_hi[k]);
			if (q < p) begin
				t = p; p = q; q = t;
			end
			lo += p;
			hi += q;
		end
	endfunction

	function automatic bit tri_box_overlap(input tri_t t);
		longint v [3][3];
		longint e [3][3];
		longint ab [3], ac [3], n [3], ax [3], unit [3];
		longint off, blo, bhi, tlo, thi, d, lo, hi;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				v[i][j] = longint'($signed(t[i*3+j]));
		for (int j = 0; j < 3; j++) begin
			lo = v[0][j]; hi = v[0][j];
			for (int i = 1; i < 3; i++) begin
				if (v[i][j] < lo) lo = v[i][j];
				if (v[i][j] > hi) hi = v[i][j];
			end
			if (hi < box_lo[j] || lo > box_hi[j])
				return 1'b0;
		end
		for (int j = 0; j < 3; j++) begin
			e[0][j] = v[0][j] - v[1][j];
			e[1][j] = v[1][j] - v[2][j];
			e[2][j] = v[2][j] - v[0][j];
			ab[j] = v[1][j] - v[0][j];
			ac[j] = v[2][j] - v[0][j];
		end
		cross3(ab, ac, n);
		off = dot3(n, v[0]);
		box_proj(n, blo, bhi);
		if (bhi < off || off < blo)
			return 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++)
					unit[k] = longint'((k == j) ? 1 : 0);
				cross3(e[i], unit, ax);
				box_proj(ax, blo, bhi);
				tlo = dot3(ax, v[0]); thi = tlo;
				for (int k = 1; k < 3; k++) begin
					d = dot3(ax, v[k]);
					if (d < tlo) tlo = d;
					if (d > thi) thi = d;
				end
				if (bhi < tlo || thi < blo)
					return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic int rnd(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic logic [15:0] sat(input int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic tri_t mk(input int ax, ay, az, bx, by, bz, cx, cy, cz);
		tri_t t;
		t = {sat(cz), sat(cy), sat(cx), sat(bz), sat(by), sat(bx), sat(az), sat(ay), sat(ax)};
		return t;
	endfunction

	task automatic reg_write(input tbo_pkg::reg_idx_t idx, input logic signed [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tbo_pkg::ADDR_W'(int'(idx) * 4);
		pwdata <= {{16{val[15]}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_box(input int lx, ly, lz, hx, hy, hz);
		reg_write(tbo_pkg::REG_MIN_X, 16'(lx));
		reg_write(tbo_pkg::REG_MIN_Y, 16'(ly));
		reg_write(tbo_pkg::REG_MIN_Z, 16'(lz));
		reg_write(tbo_pkg::REG_MAX_X, 16'(hx));
		reg_write(tbo_pkg::REG_MAX_Y, 16'(hy));
		reg_write(tbo_pkg::REG_MAX_Z, 16'(hz));
		box_lo[0] = 16'(lx); box_lo[1] = 16'(ly); box_lo[2] = 16'(lz);
		box_hi[0] = 16'(hx); box_hi[1] = 16'(hy); box_hi[2] = 16'(hz);
	endtask

	// one transfer; expectation queued at the negedge before the accepting edge
	task automatic send_tri(input tri_t t, input int want);
		bit pred;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat (rnd(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tri_in <= t;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		pred = tri_box_overlap(t);
		if (want >= 0 && pred != want[0]) begin
			$display("%0t predictor disagrees with table: expected %0d actual %0d",
				$time, want, pred);
			errors++;
		end
		overlap_q = {overlap_q, (want >= 0) ? want[0] : pred};
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (overlap_q.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic tri_t rand_tri;
		int mode, c [3], r;
		int vv [9];
		mode = rnd(0, 99);
		if (mode < 15) begin
			for (int i = 0; i < 9; i++) vv[i] = rnd(-32768, 32767);
		end else if (mode < 25) begin
			for (int i = 0; i < 9; i++)
				vv[i] = ($urandom_range(0, 1)) ? 32767 : -32768;
			if (mode < 20) for (int i = 0; i < 3; i++) vv[i+3] = rnd(-32768, 32767);
		end else begin
			for (int j = 0; j < 3; j++)
				c[j] = (box_lo[j] <= box_hi[j]) ? rnd(box_lo[j] - 8, box_hi[j] + 8)
					: rnd(box_hi[j] - 8, box_lo[j] + 8);
			case ($urandom_range(0, 3))
				0: r = 4;
				1: r = 64;
				2: r = 1024;
				default: r = 16384;
			endcase
			for (int i = 0; i < 9; i++) vv[i] = c[i % 3] + rnd(-r, r);
			if (mode < 35) begin
				// degenerate: repeated vertex or collinear
				for (int j = 0; j < 3; j++)
					vv[6+j] = (mode < 30) ? vv[j] : 2 * vv[3+j] - vv[j];
			end
		end
		return mk(vv[0], vv[1], vv[2], vv[3], vv[4], vv[5], vv[6], vv[7], vv[8]);
	endfunction

	// output side: random stall bursts
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= rnd(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (overlap_q.size() == 0) begin
				$display("%0t unexpected transfer: expected none actual overlaps=%0d",
					$time, overlaps);
				errors++;
			end else if (overlaps !== overlap_q[0]) begin
				$display("%0t overlaps mismatch: expected %0d actual %0d",
					$time, overlap_q[0], overlaps);
				errors++;
				void'(overlap_q.pop_front());
			end else begin
				void'(overlap_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 600000) begin
			$display("status: fail");
			$finish;
		end
	end

	tri_t dir_tri [10];
	int dir_exp [10];

	initial begin
		box_lo = '{0, 0, 0};
		box_hi = '{0, 0, 0};
		// box is the origin point after reset
		dir_tri[0] = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);                     dir_exp[0] = 1;
		dir_tri[1] = mk(1, 1, 1, 1, 1, 1, 1, 1, 1);                     dir_exp[1] = 0;
		dir_tri[2] = mk(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767);                                       dir_exp[2] = 0;
		dir_tri[3] = mk(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768);                                    dir_exp[3] = 0;
		dir_tri[4] = mk(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
		dir_exp[4] = 1;
		dir_tri[5] = mk(-5, 0, 0, 5, 0, 0, 0, 5, 0);                    dir_exp[5] = 1;
		dir_tri[6] = mk(1, -5, 0, 1, 5, 0, 5, 0, 0);                    dir_exp[6] = 0;
		dir_tri[7] = mk(0, 0, 0, 10, 0, 0, 0, 10, 0);                   dir_exp[7] = 1;
		dir_tri[8] = mk(-32768, 32767, 5, 32767, -32768, -5, 100, 100, -32768);
		dir_exp[8] = -1;
		dir_tri[9] = mk(3, -3, -3, -3, 3, -3, -3, -3, 3);               dir_exp[9] = -1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 10; i++) send_tri(dir_tri[i], dir_exp[i]);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_box(-32768, -32768, -32768, 32767, 32767, 32767);
				1: set_box(32767, 32767, 32767, -32768, -32768, -32768);
				2: set_box(-100, -100, -100, 100, 100, 100);
				3: set_box(rnd(-20000, 0), rnd(-20000, 0), rnd(-20000, 0),
					rnd(0, 20000), rnd(0, 20000), rnd(0, 20000));
				4: set_box(32767, -32768, 0, 32767, 32767, 0);
				5: set_box(rnd(-300, 300), rnd(-300, 300), rnd(-300, 300),
					rnd(-300, 300), rnd(-300, 300), rnd(-300, 300));
				6: set_box(rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767),
					rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767));
				default: begin
					set_box(-1000, -2000, -3000, 3000, 2000, 1000);
					quiet = 1'b1;
				end
			endcase
			for (int i = 0; i < 175; i++) send_tri(rand_tri(), -1);
			drain();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- triangle_box_overlap_test_top.f -----
+incdir+design
design/tbo_pkg.sv
design/tbo_axis_test.sv
design/triangle_box_overlap_test_top.sv
dv/tb_top.sv
